### rtl/core/srdo_pkg.sv
// Shared constants, codes, types and helpers for the sample ring.
// No dependencies; srdo_if.sv and the core use it.

package srdo_pkg;

   localparam int RING_DEPTH        = 16;
   localparam int SENSOR_COUNT      = 16;
   localparam int PAYLOAD_MAX_BYTES = 8;
   localparam int MIN_SAMPLE_BYTES  = 2;

   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int LEVEL_W    = $clog2(RING_DEPTH + 1);
   localparam int MASK_W     = 16;
   localparam int MASK_IDX_W = $clog2(MASK_W);
   localparam int ID_W       = 8;
   localparam int SIZE_IN_W  = 8;
   localparam int SENSOR_W   = 4;
   localparam int SIZE_W     = 4;
   localparam int PAYLOAD_W  = 64;
   localparam int PAYLOAD_BYTES = PAYLOAD_W / 8;
   localparam int TS_W       = 32;
   localparam int COUNT_W    = 32;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_ENABLE = CSR_IDX_W'(0);

   typedef enum logic [1:0] {
      REQ_PUSH = 2'd0,
      REQ_POP  = 2'd1,
      REQ_PEEK = 2'd2,
      REQ_NOP  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DROPPED = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_code_type;

   typedef struct packed {
      logic [TS_W-1:0]      timestamp;
      logic [SENSOR_W-1:0]  sensor;
      logic [SIZE_W-1:0]    size;
      logic [PAYLOAD_W-1:0] payload;
   } slot_type;

   typedef struct packed {
      req_code_type         req_type;
      logic [ID_W-1:0]      sensor_num;
      logic [SIZE_IN_W-1:0] sample_size;
      logic [PAYLOAD_W-1:0] payload;
      logic [TS_W-1:0]      arrival_tick;
   } req_item_type;

   typedef struct packed {
      status_code_type      status;
      slot_type             entry;
      logic [LEVEL_W-1:0]   occupancy;
      logic [LEVEL_W-1:0]   high_water;
      logic [COUNT_W-1:0]   received_count;
      logic [COUNT_W-1:0]   dropped_count;
      logic [COUNT_W-1:0]   invalid_count;
   } rsp_item_type;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

endpackage

### rtl/core/srdo_if.sv
// Valid/ready channel interfaces for the sample ring: request and response.
// Depends on srdo_pkg for field widths.

interface srdo_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       req_type;
   logic [srdo_pkg::ID_W-1:0]        sensor_num;
   logic [srdo_pkg::SIZE_IN_W-1:0]   sample_size;
   logic [srdo_pkg::PAYLOAD_W-1:0]   payload;
   logic [srdo_pkg::TS_W-1:0]        arrival_tick;

   modport source (output valid, req_type, sensor_num, sample_size, payload, arrival_tick,
                   input ready);
   modport sink   (input valid, req_type, sensor_num, sample_size, payload, arrival_tick,
                   output ready);
endinterface

interface srdo_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       status;
   logic [srdo_pkg::TS_W-1:0]        out_timestamp;
   logic [srdo_pkg::SENSOR_W-1:0]    out_sensor;
   logic [srdo_pkg::SIZE_W-1:0]      out_size;
   logic [srdo_pkg::PAYLOAD_W-1:0]   out_payload;
   logic [srdo_pkg::LEVEL_W-1:0]     occupancy;
   logic [srdo_pkg::LEVEL_W-1:0]     high_water;
   logic [srdo_pkg::COUNT_W-1:0]     received_count;
   logic [srdo_pkg::COUNT_W-1:0]     dropped_count;
   logic [srdo_pkg::COUNT_W-1:0]     invalid_count;

   modport source (output valid, status, out_timestamp, out_sensor, out_size, out_payload,
                   occupancy, high_water, received_count, dropped_count, invalid_count,
                   input ready);
   modport sink   (input valid, status, out_timestamp, out_sensor, out_size, out_payload,
                   occupancy, high_water, received_count, dropped_count, invalid_count,
                   output ready);
endinterface

### rtl/core/srdo_slots.sv
// Generic RAM: one write port, one read port with registered read data.
// No dependencies; a read of the word being written returns the new word.

module srdo_slots #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && wr_addr == rd_addr) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/sample_ring_drop_oldest_core.sv
// Top level of the sample ring: request register, single-pass ring update, response register.
// Depends on srdo_pkg, srdo_if.sv and srdo_slots.

// A queue of sensor samples in a 16-slot ring. Push stores a checked sample at the
// tail (dropping the oldest entry when full), pop and peek return the head. Each
// request gives exactly one response, through the request and response registers, and
// one request is taken every cycle while responses are taken: the request register feeds
// one pass of pointer, level and counter update plus the head slot, which the slot RAM
// holds in its read register. A stalled response holds the request stage and with it
// new requests. Slot contents need no clearing after reset. The enable mask sits at byte
// address 0 of the APB port and reads back in the low 16 bits.

module sample_ring_drop_oldest_core (
   input  logic                             clock,
   input  logic                             reset,
   srdo_req_if.sink                         req,
   srdo_rsp_if.source                       rsp,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [srdo_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [srdo_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [srdo_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   localparam int LW = srdo_pkg::LEVEL_W;
   localparam int CW = srdo_pkg::COUNT_W;

   logic [srdo_pkg::MASK_W-1:0]   enable_mask_ff;
   logic [srdo_pkg::CSR_IDX_W-1:0] csr_idx;

   logic                          s1_valid_ff, s1_valid_in;
   srdo_pkg::req_item_type        s1_item_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   srdo_pkg::rsp_item_type        rsp_ff, rsp_in;
   logic                          s2_load;

   logic [srdo_pkg::PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [srdo_pkg::PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]                 fill_ff, fill_in;
   logic [LW-1:0]                 peak_ff, peak_in;
   logic [CW-1:0]                 accepted_ff, accepted_in;
   logic [CW-1:0]                 overwritten_ff, overwritten_in;
   logic [CW-1:0]                 rejected_ff, rejected_in;

   logic                          push_ok;
   logic                          slot_wr;
   srdo_pkg::slot_type            slot_wdata;
   srdo_pkg::slot_type            head;
   logic [srdo_pkg::PTR_W-1:0]    head_addr;
   logic [srdo_pkg::PAYLOAD_W-1:0] kept_payload;

   // Configuration port
   assign pready  = 1'b1;
   assign csr_idx = paddr[srdo_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= '0;
      end else if (psel && penable && pwrite && pready &&
                   csr_idx == srdo_pkg::CSR_SENSOR_ENABLE) begin
         enable_mask_ff <= pwdata[srdo_pkg::MASK_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_idx == srdo_pkg::CSR_SENSOR_ENABLE) begin
         prdata = srdo_pkg::CSR_DATA_W'(enable_mask_ff);
      end
   end

   // Handshake: request stage advances whenever the response register is free
   assign s2_load   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s2_load;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req.valid && req.ready) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_item_ff.req_type     <= srdo_pkg::req_code_type'(req.req_type);
         s1_item_ff.sensor_num   <= req.sensor_num;
         s1_item_ff.sample_size  <= req.sample_size;
         s1_item_ff.payload      <= req.payload;
         s1_item_ff.arrival_tick <= req.arrival_tick;
      end
      if (s2_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Sample checks, applied to the held request
   assign push_ok =
      (s1_item_ff.sample_size >= srdo_pkg::SIZE_IN_W'(srdo_pkg::MIN_SAMPLE_BYTES)) &&
      (s1_item_ff.sample_size <= srdo_pkg::SIZE_IN_W'(srdo_pkg::PAYLOAD_MAX_BYTES)) &&
      (s1_item_ff.sensor_num < srdo_pkg::ID_W'(srdo_pkg::SENSOR_COUNT)) &&
      (s1_item_ff.sensor_num < srdo_pkg::ID_W'(srdo_pkg::MASK_W)) &&
      enable_mask_ff[s1_item_ff.sensor_num[srdo_pkg::MASK_IDX_W-1:0]];

   // Zero the bytes at and beyond the sample size
   always_comb begin
      for (int b = 0; b < srdo_pkg::PAYLOAD_BYTES; b++) begin
         kept_payload[b*8 +: 8] =
            (s1_item_ff.sample_size > srdo_pkg::SIZE_IN_W'(b)) ?
            s1_item_ff.payload[b*8 +: 8] : 8'h00;
      end
   end

   assign slot_wdata.timestamp = s1_item_ff.arrival_tick;
   assign slot_wdata.sensor    = s1_item_ff.sensor_num[srdo_pkg::SENSOR_W-1:0];
   assign slot_wdata.size      = s1_item_ff.sample_size[srdo_pkg::SIZE_W-1:0];
   assign slot_wdata.payload   = kept_payload;

   // Read ahead the slot that will be the head after this edge
   assign head_addr = s2_load ? rd_ptr_in : rd_ptr_ff;

   srdo_slots #(
      .WIDTH ($bits(srdo_pkg::slot_type)),
      .DEPTH (srdo_pkg::RING_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (slot_wr),
      .wr_addr (wr_ptr_ff),
      .wr_data (slot_wdata),
      .rd_addr (head_addr),
      .rd_data (head)
   );

   // Ring update and response for the held request
   always_comb begin
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      fill_in        = fill_ff;
      peak_in        = peak_ff;
      accepted_in    = accepted_ff;
      overwritten_in = overwritten_ff;
      rejected_in    = rejected_ff;
      slot_wr        = 1'b0;
      rsp_in.status  = srdo_pkg::STATUS_OK;
      rsp_in.entry   = '0;
      case (s1_item_ff.req_type)
         srdo_pkg::REQ_PUSH: begin
            if (!push_ok) begin
               rejected_in   = rejected_ff + CW'(1);
               rsp_in.status = srdo_pkg::STATUS_INVALID;
            end else begin
               slot_wr     = s2_load;
               wr_ptr_in   = srdo_pkg::advance(wr_ptr_ff);
               accepted_in = accepted_ff + CW'(1);
               if (fill_ff == LW'(srdo_pkg::RING_DEPTH)) begin
                  // drop the oldest to make room
                  rd_ptr_in      = srdo_pkg::advance(rd_ptr_ff);
                  overwritten_in = overwritten_ff + CW'(1);
                  rsp_in.status  = srdo_pkg::STATUS_DROPPED;
               end else begin
                  fill_in = fill_ff + LW'(1);
                  if (fill_ff + LW'(1) > peak_ff) begin
                     peak_in = fill_ff + LW'(1);
                  end
               end
            end
         end
         srdo_pkg::REQ_POP, srdo_pkg::REQ_PEEK: begin
            if (fill_ff == '0) begin
               rsp_in.status = srdo_pkg::STATUS_EMPTY;
            end else begin
               rsp_in.entry = head;
               if (s1_item_ff.req_type == srdo_pkg::REQ_POP) begin
                  rd_ptr_in = srdo_pkg::advance(rd_ptr_ff);
                  fill_in   = fill_ff - LW'(1);
               end
            end
         end
         default: begin
         end
      endcase
      rsp_in.occupancy      = fill_in;
      rsp_in.high_water     = peak_in;
      rsp_in.received_count = accepted_in;
      rsp_in.dropped_count  = overwritten_in;
      rsp_in.invalid_count  = rejected_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         fill_ff        <= '0;
         peak_ff        <= '0;
         accepted_ff    <= '0;
         overwritten_ff <= '0;
         rejected_ff    <= '0;
      end else if (s2_load) begin
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         fill_ff        <= fill_in;
         peak_ff        <= peak_in;
         accepted_ff    <= accepted_in;
         overwritten_ff <= overwritten_in;
         rejected_ff    <= rejected_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_ff.status;
   assign rsp.out_timestamp  = rsp_ff.entry.timestamp;
   assign rsp.out_sensor     = rsp_ff.entry.sensor;
   assign rsp.out_size       = rsp_ff.entry.size;
   assign rsp.out_payload    = rsp_ff.entry.payload;
   assign rsp.occupancy      = rsp_ff.occupancy;
   assign rsp.high_water     = rsp_ff.high_water;
   assign rsp.received_count = rsp_ff.received_count;
   assign rsp.dropped_count  = rsp_ff.dropped_count;
   assign rsp.invalid_count  = rsp_ff.invalid_count;

`ifndef SYNTH
   a_level_bounds: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LW'(srdo_pkg::RING_DEPTH) && peak_ff >= fill_ff)
      else $error("fill level above depth or above high-water mark");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == LW'(srdo_pkg::RING_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("pointers disagree with empty or full ring");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == srdo_pkg::STATUS_DROPPED) |->
      rsp.occupancy == LW'(srdo_pkg::RING_DEPTH))
      else $error("oldest dropped while ring not full");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == srdo_pkg::STATUS_EMPTY) |->
      (rsp.occupancy == '0 && rsp.out_payload == '0))
      else $error("empty status with entries held");

   a_push_advance: assert property (@(posedge clock) disable iff (reset)
      slot_wr |=> wr_ptr_ff == srdo_pkg::advance($past(wr_ptr_ff)))
      else $error("tail did not advance after slot write");
`endif

endmodule

### tb/tb_sample_ring_drop_oldest_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for sample_ring_drop_oldest_core: a directed table, then random
// phases under several enable masks, each result checked against a table entry or an in-bench ring predictor.
// Depends on srdo_pkg, srdo_if.sv and the core.

module tb_sample_ring_drop_oldest_core;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int HOLD_CYCLES = 120;
   localparam int PHASE_COUNT = 6;
   localparam logic [srdo_pkg::CSR_IDX_W-1:0] UNMAPPED_REG = srdo_pkg::CSR_IDX_W'(1);

   typedef struct {
      bit                     write_cfg;
      logic [31:0]            cfg_value;
      srdo_pkg::req_item_type item;
      int unsigned            copies;
      bit                     typed;
      srdo_pkg::rsp_item_type want;
   } plan_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [srdo_pkg::CSR_ADDR_W-1:0] paddr;
   logic [srdo_pkg::CSR_DATA_W-1:0] pwdata;
   logic [srdo_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   srdo_req_if req_ch ();
   srdo_rsp_if rsp_ch ();

   sample_ring_drop_oldest_core uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ring predictor state
   srdo_pkg::slot_type ring_slot [srdo_pkg::RING_DEPTH];
   int unsigned  ring_head = 0;
   int unsigned  ring_tail = 0;
   int unsigned  ring_fill = 0;
   int unsigned  ring_peak = 0;
   logic [31:0]  accepted_total = '0;
   logic [31:0]  dropped_total = '0;
   logic [31:0]  rejected_total = '0;
   logic [15:0]  enable_mask = '0;

   srdo_pkg::rsp_item_type pending_results [$];
   plan_row_type plan [$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   bit           quiet = 1'b0;
   bit           hold_req = 1'b0;

   int          phase_items [PHASE_COUNT] = '{250, 250, 100, 100, 50, 250};
   int          phase_push  [PHASE_COUNT] = '{70, 45, 60, 60, 50, 55};
   logic [31:0] phase_mask  [PHASE_COUNT] = '{32'h0000_ffff, 32'h0, 32'h0000_0001,
                                              32'h0000_8000, 32'h0, 32'h0};
   bit          phase_random_mask [PHASE_COUNT] = '{0, 1, 0, 0, 0, 1};
   bit          phase_quiet       [PHASE_COUNT] = '{0, 0, 1, 0, 0, 0};

   function automatic srdo_pkg::rsp_item_type predict_ring_result(
      input srdo_pkg::req_item_type it);
      srdo_pkg::rsp_item_type r;
      logic [63:0]            keep;
      r = '0;
      r.status = srdo_pkg::STATUS_OK;
      case (it.req_type)
         srdo_pkg::REQ_PUSH: begin
            if (it.sample_size < srdo_pkg::MIN_SAMPLE_BYTES ||
                it.sample_size > srdo_pkg::PAYLOAD_MAX_BYTES ||
                it.sensor_num >= srdo_pkg::SENSOR_COUNT ||
                !enable_mask[it.sensor_num[3:0]]) begin
               rejected_total++;
               r.status = srdo_pkg::STATUS_INVALID;
            end else begin
               if (ring_fill == srdo_pkg::RING_DEPTH) begin
                  // drop the oldest entry to make room
                  ring_head = (ring_head + 1) % srdo_pkg::RING_DEPTH;
                  ring_fill--;
                  dropped_total++;
                  r.status = srdo_pkg::STATUS_DROPPED;
               end
               keep = (it.sample_size >= srdo_pkg::PAYLOAD_BYTES) ? '1
                    : (64'd1 << (8 * it.sample_size)) - 64'd1;
               ring_slot[ring_tail].timestamp = it.arrival_tick;
               ring_slot[ring_tail].sensor    = it.sensor_num[srdo_pkg::SENSOR_W-1:0];
               ring_slot[ring_tail].size      = it.sample_size[srdo_pkg::SIZE_W-1:0];
               ring_slot[ring_tail].payload   = it.payload & keep;
               ring_tail = (ring_tail + 1) % srdo_pkg::RING_DEPTH;
               ring_fill++;
               if (ring_fill > ring_peak) ring_peak = ring_fill;
               accepted_total++;
            end
         end
         srdo_pkg::REQ_POP, srdo_pkg::REQ_PEEK: begin
            if (ring_fill == 0) begin
               r.status = srdo_pkg::STATUS_EMPTY;
            end else begin
               r.entry = ring_slot[ring_head];
               if (it.req_type == srdo_pkg::REQ_POP) begin
                  ring_head = (ring_head + 1) % srdo_pkg::RING_DEPTH;
                  ring_fill--;
               end
            end
         end
         default: ;
      endcase
      r.occupancy      = srdo_pkg::LEVEL_W'(ring_fill);
      r.high_water     = srdo_pkg::LEVEL_W'(ring_peak);
      r.received_count = accepted_total;
      r.dropped_count  = dropped_total;
      r.invalid_count  = rejected_total;
      return r;
   endfunction

   function automatic srdo_pkg::req_item_type mk_req(input srdo_pkg::req_code_type code,
                                                     input int id, input int size,
                                                     input logic [63:0] data,
                                                     input logic [31:0] ts);
      srdo_pkg::req_item_type it;
      it.req_type     = code;
      it.sensor_num   = srdo_pkg::ID_W'(id);
      it.sample_size  = srdo_pkg::SIZE_IN_W'(size);
      it.payload      = data;
      it.arrival_tick = ts;
      return it;
   endfunction

   function automatic srdo_pkg::rsp_item_type mk_status(
      input srdo_pkg::status_code_type st, input int occ, input int hw, input int rc,
      input int dc, input int ic);
      srdo_pkg::rsp_item_type r;
      r = '0;
      r.status         = st;
      r.occupancy      = srdo_pkg::LEVEL_W'(occ);
      r.high_water     = srdo_pkg::LEVEL_W'(hw);
      r.received_count = srdo_pkg::COUNT_W'(rc);
      r.dropped_count  = srdo_pkg::COUNT_W'(dc);
      r.invalid_count  = srdo_pkg::COUNT_W'(ic);
      return r;
   endfunction

   function automatic void add_row(input bit write_cfg, input logic [31:0] cfg_value,
                                   input srdo_pkg::req_item_type it,
                                   input int unsigned copies, input bit typed,
                                   input srdo_pkg::rsp_item_type want);
      plan_row_type row;
      row.write_cfg = write_cfg;
      row.cfg_value = cfg_value;
      row.item      = it;
      row.copies    = copies;
      row.typed     = typed;
      row.want      = want;
      plan.push_back(row);
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // Called and returns at a falling edge; valid stays high on return.
   task automatic send_request(input srdo_pkg::req_item_type it, input bit typed,
                               input srdo_pkg::rsp_item_type want);
      srdo_pkg::rsp_item_type pred;
      while (!quiet && $urandom_range(99) < 11) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= it.req_type;
      req_ch.sensor_num   <= it.sensor_num;
      req_ch.sample_size  <= it.sample_size;
      req_ch.payload      <= it.payload;
      req_ch.arrival_tick <= it.arrival_tick;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pred = predict_ring_result(it);
      pending_results.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write one register, then read the enable mask back.
   task automatic csr_write(input logic [srdo_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (idx == srdo_pkg::CSR_SENSOR_ENABLE) enable_mask = value[15:0];
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {srdo_pkg::CSR_SENSOR_ENABLE, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      check_field("enable mask readback", enable_mask, prdata[15:0]);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_ch.ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 11);
      end
   end

   always @(posedge clock) begin : check_results
      srdo_pkg::rsp_item_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: result with nothing expected, status %0d", $time,
                     rsp_ch.status);
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_ch.status);
            check_field("out_timestamp", want.entry.timestamp, rsp_ch.out_timestamp);
            check_field("out_sensor", want.entry.sensor, rsp_ch.out_sensor);
            check_field("out_size", want.entry.size, rsp_ch.out_size);
            check_field("out_payload", want.entry.payload, rsp_ch.out_payload);
            check_field("occupancy", want.occupancy, rsp_ch.occupancy);
            check_field("high_water", want.high_water, rsp_ch.high_water);
            check_field("received_count", want.received_count, rsp_ch.received_count);
            check_field("dropped_count", want.dropped_count, rsp_ch.dropped_count);
            check_field("invalid_count", want.invalid_count, rsp_ch.invalid_count);
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_sample_ring_drop_oldest_core: errors");
      $finish;
   end

   initial begin : stimulus
      srdo_pkg::req_item_type it;
      logic [15:0]  cur_mask;
      int unsigned  kind;
      int unsigned  id;

      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = '0;
      req_ch.sensor_num   = '0;
      req_ch.sample_size  = '0;
      req_ch.payload      = '0;
      req_ch.arrival_tick = '0;

      // empty ring and disabled sensors right after reset
      add_row(0, 0, mk_req(srdo_pkg::REQ_POP, 0, 0, 0, 0), 1, 1,
              mk_status(srdo_pkg::STATUS_EMPTY, 0, 0, 0, 0, 0));
      add_row(0, 0, mk_req(srdo_pkg::REQ_PEEK, 0, 0, 0, 0), 1, 1,
              mk_status(srdo_pkg::STATUS_EMPTY, 0, 0, 0, 0, 0));
      add_row(0, 0, mk_req(srdo_pkg::REQ_NOP, 255, 255, '1, '1), 1, 1,
              mk_status(srdo_pkg::STATUS_OK, 0, 0, 0, 0, 0));
      add_row(0, 0, mk_req(srdo_pkg::REQ_PUSH, 0, 8, 64'h0123_4567_89ab_cdef, 32'h10), 1, 1,
              mk_status(srdo_pkg::STATUS_INVALID, 0, 0, 0, 0, 1));
      // enable all; upper data bits of the write must be ignored
      add_row(1, 32'hffff_ffff, mk_req(srdo_pkg::REQ_PUSH, 0, 1, '1, 32'h11), 1, 1,
              mk_status(srdo_pkg::STATUS_INVALID, 0, 0, 0, 0, 2));
      add_row(0, 0, mk_req(srdo_pkg::REQ_PUSH, 1, 9, '1, 32'h12), 1, 1,
              mk_status(srdo_pkg::STATUS_INVALID, 0, 0, 0, 0, 3));
      add_row(0, 0, mk_req(srdo_pkg::REQ_PUSH, 16, 8, '1, 32'h13), 1, 1,
              mk_status(srdo_pkg::STATUS_INVALID, 0, 0, 0, 0, 4));
      add_row(0, 0, mk_req(srdo_pkg::REQ_PUSH, 255, 255, '1, 32'h14), 1, 1,
              mk_status(srdo_pkg::STATUS_INVALID, 0, 0, 0, 0, 5));
      // short payload, then widest payload at the top sensor id
      add_row(0, 0, mk_req(srdo_pkg::REQ_PUSH, 0, 2, '1, 32'h0), 1, 0, '0);
      add_row(0, 0, mk_req(srdo_pkg::REQ_PUSH, 15, 8, '1, '1), 1, 0, '0);
      add_row(0, 0, mk_req(srdo_pkg::REQ_PEEK, 0, 0, 0, 0), 1, 0, '0);
      add_row(0, 0, mk_req(srdo_pkg::REQ_POP, 0, 0, 0, 0), 1, 0, '0);
      // sensor 15 disabled
      add_row(1, 32'h0000_7fff, mk_req(srdo_pkg::REQ_PUSH, 15, 4, '1, 32'h20), 1, 0, '0);
      // overfill: last copy drops the oldest
      add_row(0, 0, mk_req(srdo_pkg::REQ_PUSH, 14, 3, 64'hfedc_ba98_7654_3210, 32'h100),
              16, 0, '0);
      add_row(0, 0, mk_req(srdo_pkg::REQ_PEEK, 0, 0, 0, 0), 1, 0, '0);
      add_row(0, 0, mk_req(srdo_pkg::REQ_POP, 0, 0, 0, 0), 2, 0, '0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].write_cfg) begin
            wait_drained();
            csr_write(srdo_pkg::CSR_SENSOR_ENABLE, plan[i].cfg_value);
         end
         it = plan[i].item;
         for (int k = 0; k < plan[i].copies; k++) begin
            send_request(it, plan[i].typed, plan[i].want);
            it.arrival_tick = it.arrival_tick + 32'd1;
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         csr_write(UNMAPPED_REG, $urandom);
         csr_write(srdo_pkg::CSR_SENSOR_ENABLE,
                   phase_random_mask[p] ? $urandom : phase_mask[p]);
         cur_mask = enable_mask;
         quiet = phase_quiet[p];
         if (p == 0) hold_req = 1'b1;
         for (int n = 0; n < phase_items[p]; n++) begin
            it.payload      = {$urandom, $urandom};
            it.arrival_tick = $urandom;
            it.sensor_num   = srdo_pkg::ID_W'($urandom);
            it.sample_size  = srdo_pkg::SIZE_IN_W'($urandom);
            kind = $urandom_range(99);
            if (kind < phase_push[p]) begin
               it.req_type = srdo_pkg::REQ_PUSH;
               // mostly well-formed pushes from enabled sensors, some noise
               if ($urandom_range(99) >= 15 && cur_mask != '0) begin
                  do id = $urandom_range(srdo_pkg::SENSOR_COUNT - 1); while (!cur_mask[id]);
                  it.sensor_num  = srdo_pkg::ID_W'(id);
                  it.sample_size = srdo_pkg::SIZE_IN_W'(
                     $urandom_range(srdo_pkg::PAYLOAD_MAX_BYTES, srdo_pkg::MIN_SAMPLE_BYTES));
               end
            end else if (kind < 88) begin
               it.req_type = srdo_pkg::REQ_POP;
            end else if (kind < 97) begin
               it.req_type = srdo_pkg::REQ_PEEK;
            end else begin
               it.req_type = srdo_pkg::REQ_NOP;
            end
            send_request(it, 1'b0, '0);
         end
      end

      quiet = 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_sample_ring_drop_oldest_core: clean");
      end else begin
         $display("tb_sample_ring_drop_oldest_core: errors");
      end
      $finish;
   end

endmodule
